// File: sv/box_filter_3x3_zero_pad_core_defines.svh
// assertion macros for the 3x3 box filter core
// used by files that carry concurrent checks; no other dependencies
`ifndef BOX_FILTER_3X3_ZERO_PAD_CORE_DEFINES_SVH
`define BOX_FILTER_3X3_ZERO_PAD_CORE_DEFINES_SVH

// generic clocked check, disabled while reset is asserted
`define BF3_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("box filter check failed");

// same-cycle implication on clk_i / rst_ni
`define BF3_ASSERT_IMPL(lbl, ante, cons) \
  `BF3_ASSERT(lbl, clk_i, rst_ni, (ante) |-> (cons))

// next-cycle implication on clk_i / rst_ni
`define BF3_ASSERT_NEXT(lbl, ante, cons) \
  `BF3_ASSERT(lbl, clk_i, rst_ni, (ante) |=> (cons))

`endif

// File: sv/bf3_pkg.sv
// shared types and constants for the 3x3 box filter core
// no dependencies; used by bf3_mean and box_filter_3x3_zero_pad_core
package bf3_pkg;

  localparam int unsigned MaxWidth  = 2048;
  localparam int unsigned MaxHeight = 4096;
  localparam int unsigned Channels  = 3;
  localparam int unsigned SampleW   = 8;

  // counter and frame size widths
  localparam int unsigned ColW    = $clog2(MaxWidth);
  localparam int unsigned WEffW   = $clog2(MaxWidth + 1);
  localparam int unsigned HEffW   = $clog2(MaxHeight + 1);
  localparam int unsigned OutRowW = $clog2(MaxHeight);
  localparam int unsigned InRowW  = $clog2(MaxHeight + 2);

  // configuration port
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 13;
  localparam int unsigned CfgWidthFieldW  = 12;
  localparam int unsigned CfgHeightFieldW = 13;
  localparam int unsigned WidthReset  = 640;
  localparam int unsigned HeightReset = 480;

  typedef enum logic [CfgIdxW-1:0] {
    CfgFrameWidth  = 8'd0,
    CfgFrameHeight = 8'd1
  } cfg_idx_e;

  // stream payloads
  localparam int unsigned StreamFields = 3;
  localparam int unsigned DataW        = StreamFields * SampleW;

  // divide by 9: floor(s / 9) == (s * 3641) >> 15 for s below 32768
  localparam int unsigned SumW     = SampleW + 4;
  localparam int unsigned DivMul   = 3641;
  localparam int unsigned DivMulW  = 12;
  localparam int unsigned DivShift = 15;
  localparam int unsigned ProdW    = SumW + DivMulW;

  typedef logic [Channels-1:0][SampleW-1:0] pix_t;
  typedef pix_t [2:0][2:0] win_t;  // [column][row], column 2 is newest

  typedef struct packed {
    pix_t upper;
    pix_t lower;
  } line_t;

  // per-item control computed at the input, carried with the item
  typedef struct packed {
    logic emit;
    logic col_lo_ok;
    logic col_hi_ok;
    logic row_lo_ok;
    logic row_hi_ok;
    logic row_end;
    logic frame_end;
  } ctl_t;

endpackage

// File: sv/bf3_mean.sv
// 3x3 window, masked neighborhood sum and divide by nine
// depends on bf3_pkg; instantiated by box_filter_3x3_zero_pad_core
module bf3_mean (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          clear_i,
  input  logic          valid_i,
  input  bf3_pkg::pix_t top_i,
  input  bf3_pkg::pix_t mid_i,
  input  bf3_pkg::pix_t bot_i,
  input  bf3_pkg::ctl_t ctl_i,
  output logic          valid_o,
  output bf3_pkg::pix_t avg_o,
  output logic          row_end_o,
  output logic          frame_end_o
);

  bf3_pkg::win_t win_q, win_d;

  logic          b_valid_q;
  bf3_pkg::ctl_t b_ctl_q;

  logic                                       c_valid_q;
  logic [bf3_pkg::Channels-1:0][bf3_pkg::SumW-1:0] c_sum_q, sum_d;
  logic                                       c_row_end_q;
  logic                                       c_frame_end_q;

  logic                                        out_valid_q;
  bf3_pkg::pix_t                               avg_q, avg_d;
  logic                                        out_row_end_q;
  logic                                        out_frame_end_q;
  logic [bf3_pkg::Channels-1:0][bf3_pkg::ProdW-1:0] prod;

  logic [2:0] col_ok, row_ok;

  // window shifts one column per item
  always_comb begin
    win_d[0]    = win_q[1];
    win_d[1]    = win_q[2];
    win_d[2][0] = top_i;
    win_d[2][1] = mid_i;
    win_d[2][2] = bot_i;
  end

  // taps outside the frame are masked to zero
  always_comb begin
    col_ok = {b_ctl_q.col_hi_ok, 1'b1, b_ctl_q.col_lo_ok};
    row_ok = {b_ctl_q.row_hi_ok, 1'b1, b_ctl_q.row_lo_ok};
    for (int c = 0; c < bf3_pkg::Channels; c++) begin
      sum_d[c] = '0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          if (col_ok[i] && row_ok[j]) begin
            sum_d[c] = sum_d[c] + bf3_pkg::SumW'(win_q[i][j][c]);
          end
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < bf3_pkg::Channels; c++) begin
      prod[c]  = bf3_pkg::ProdW'(c_sum_q[c]) *
                 bf3_pkg::ProdW'(bf3_pkg::DivMul);
      avg_d[c] = prod[c][bf3_pkg::DivShift +: bf3_pkg::SampleW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= '0;
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (clear_i) begin
        win_q <= '0;
      end else if (en_i && valid_i) begin
        win_q <= win_d;
      end
      if (en_i) begin
        b_valid_q   <= valid_i && ctl_i.emit;
        c_valid_q   <= b_valid_q;
        out_valid_q <= c_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_ctl_q         <= ctl_i;
      c_sum_q         <= sum_d;
      c_row_end_q     <= b_ctl_q.row_end;
      c_frame_end_q   <= b_ctl_q.frame_end;
      avg_q           <= avg_d;
      out_row_end_q   <= c_row_end_q;
      out_frame_end_q <= c_frame_end_q;
    end
  end

  assign valid_o     = out_valid_q;
  assign avg_o       = avg_q;
  assign row_end_o   = out_row_end_q;
  assign frame_end_o = out_frame_end_q;

endmodule

// File: sv/box_filter_3x3_zero_pad_core.sv
// top level of the streaming 3x3 box filter with zero padding
// depends on bf3_pkg, bf3_mean and box_filter_3x3_zero_pad_core_defines.svh
//
//   channel   direction  handshake                  payload
//   s_axis    in         s_axis_tvalid/tready       tdata chan0..2, tuser opcode
//   m_axis    out        m_axis_tvalid/tready       tdata avg0..2, tlast row_end,
//                                                   tuser frame_end
//   cfg       in         cfg_valid_i/cfg_ready_o    cfg_index_i, cfg_data_i
//
// one pixel or flush request per clock unless the output stalls; a result
// moves from its releasing request through input reg, window, sum, output reg
// line store is one 2048 x 48 memory with one write and one read port
// no clearing pass after reset; unwritten store entries only feed masked taps
// a stalled output holds the whole pipeline; s_axis_tready follows that stall
`include "box_filter_3x3_zero_pad_core_defines.svh"

module box_filter_3x3_zero_pad_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [bf3_pkg::DataW-1:0]       s_axis_tdata,   // chan0, chan1, chan2
  input  logic                            s_axis_tuser,   // opcode
  // output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [bf3_pkg::DataW-1:0]       m_axis_tdata,   // avg0, avg1, avg2
  output logic                            m_axis_tlast,   // row_end
  output logic                            m_axis_tuser,   // frame_end
  // configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bf3_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [bf3_pkg::CfgDataW-1:0]    cfg_data_i
);

  localparam int unsigned ColW    = bf3_pkg::ColW;
  localparam int unsigned WEffW   = bf3_pkg::WEffW;
  localparam int unsigned HEffW   = bf3_pkg::HEffW;
  localparam int unsigned OutRowW = bf3_pkg::OutRowW;
  localparam int unsigned InRowW  = bf3_pkg::InRowW;

  // frame size, held already clamped
  logic [WEffW-1:0] w_eff_q, w_eff_d;
  logic [HEffW-1:0] h_eff_q, h_eff_d;
  logic             cfg_we;

  logic [bf3_pkg::CfgWidthFieldW-1:0]  cfg_w_raw;
  logic [bf3_pkg::CfgHeightFieldW-1:0] cfg_h_raw;

  // position counters
  logic [ColW-1:0]    in_col_q, in_col_d;
  logic [InRowW-1:0]  in_row_q, in_row_d;
  logic [ColW-1:0]    out_col_q, out_col_d;
  logic [OutRowW-1:0] out_row_q, out_row_d;

  logic          en;
  logic          accept;
  logic          is_pixel;
  logic          last_in_col;
  logic          last_out_col;
  logic          last_out_row;
  bf3_pkg::ctl_t ctl_d;
  bf3_pkg::pix_t sample_d;

  // input register
  logic          a_valid_q;
  logic [ColW-1:0] a_x_q;
  bf3_pkg::pix_t a_sample_q;
  bf3_pkg::ctl_t a_ctl_q;

  // line store
  bf3_pkg::line_t  line_mem [bf3_pkg::MaxWidth];
  bf3_pkg::line_t  rd_raw_q;
  bf3_pkg::line_t  fwd_data_q;
  logic            fwd_q;
  bf3_pkg::line_t  rd_line;
  bf3_pkg::line_t  wr_line;
  logic            wr_en;
  logic            rd_en;
  logic            fwd_d;

  bf3_pkg::pix_t avg;
  logic          out_valid;
  logic          out_row_end;
  logic          out_frame_end;

  // ---------------- configuration ----------------

  assign cfg_ready_o = 1'b1;
  assign cfg_w_raw   = cfg_data_i[bf3_pkg::CfgWidthFieldW-1:0];
  assign cfg_h_raw   = cfg_data_i[bf3_pkg::CfgHeightFieldW-1:0];

  always_comb begin
    cfg_we  = 1'b0;
    w_eff_d = w_eff_q;
    h_eff_d = h_eff_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        bf3_pkg::CfgFrameWidth: begin
          cfg_we = 1'b1;
          if (cfg_w_raw == '0) begin
            w_eff_d = WEffW'(1);
          end else if (32'(cfg_w_raw) > bf3_pkg::MaxWidth) begin
            w_eff_d = WEffW'(bf3_pkg::MaxWidth);
          end else begin
            w_eff_d = WEffW'(cfg_w_raw);
          end
        end
        bf3_pkg::CfgFrameHeight: begin
          cfg_we = 1'b1;
          if (cfg_h_raw == '0) begin
            h_eff_d = HEffW'(1);
          end else if (32'(cfg_h_raw) > bf3_pkg::MaxHeight) begin
            h_eff_d = HEffW'(bf3_pkg::MaxHeight);
          end else begin
            h_eff_d = HEffW'(cfg_h_raw);
          end
        end
        default: begin
          cfg_we = 1'b0;
        end
      endcase
    end
  end

  // ---------------- position control ----------------

  assign en            = !out_valid || m_axis_tready;
  assign s_axis_tready = en;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    is_pixel     = !s_axis_tuser && (HEffW'(in_row_q) < h_eff_q);
    last_in_col  = (WEffW'(in_col_q) + WEffW'(1)) == w_eff_q;
    last_out_col = (WEffW'(out_col_q) + WEffW'(1)) == w_eff_q;
    last_out_row = (HEffW'(out_row_q) + HEffW'(1)) == h_eff_q;

    // results start one row plus one pixel into the frame
    ctl_d.emit      = !((in_row_q == '0) ||
                        ((in_row_q == InRowW'(1)) && (in_col_q == '0)));
    ctl_d.col_lo_ok = out_col_q != '0;
    ctl_d.col_hi_ok = !last_out_col;
    ctl_d.row_lo_ok = out_row_q != '0;
    ctl_d.row_hi_ok = !last_out_row;
    ctl_d.row_end   = last_out_col;
    ctl_d.frame_end = last_out_col && last_out_row;

    for (int c = 0; c < bf3_pkg::Channels; c++) begin
      if (is_pixel && (c < bf3_pkg::StreamFields)) begin
        sample_d[c] = s_axis_tdata[c*bf3_pkg::SampleW +: bf3_pkg::SampleW];
      end else begin
        sample_d[c] = '0;
      end
    end
  end

  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (cfg_we) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
    end else if (accept) begin
      if (last_in_col) begin
        in_col_d = '0;
        in_row_d = in_row_q + InRowW'(1);
      end else begin
        in_col_d = in_col_q + ColW'(1);
      end
      if (ctl_d.emit) begin
        if (ctl_d.frame_end) begin
          in_col_d  = '0;
          in_row_d  = '0;
          out_col_d = '0;
          out_row_d = '0;
        end else if (last_out_col) begin
          out_col_d = '0;
          out_row_d = out_row_q + OutRowW'(1);
        end else begin
          out_col_d = out_col_q + ColW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_eff_q   <= WEffW'(bf3_pkg::WidthReset);
      h_eff_q   <= HEffW'(bf3_pkg::HeightReset);
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      a_valid_q <= 1'b0;
      fwd_q     <= 1'b0;
    end else begin
      w_eff_q   <= w_eff_d;
      h_eff_q   <= h_eff_d;
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      if (en) begin
        a_valid_q <= accept;
      end
      if (rd_en) begin
        fwd_q <= fwd_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_x_q      <= in_col_q;
      a_sample_q <= sample_d;
      a_ctl_q    <= ctl_d;
    end
  end

  // ---------------- line store ----------------

  // the item leaving the input register writes its column back; with a
  // one-pixel row a request accepted in that cycle reads that same column
  assign wr_en         = en && a_valid_q;
  assign rd_en         = accept;
  assign wr_line.upper = rd_line.lower;
  assign wr_line.lower = a_sample_q;
  assign fwd_d         = wr_en && (a_x_q == in_col_q);
  assign rd_line       = fwd_q ? fwd_data_q : rd_raw_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      line_mem[a_x_q] <= wr_line;
    end
    if (rd_en) begin
      rd_raw_q   <= line_mem[in_col_q];
      fwd_data_q <= wr_line;
    end
  end

  // ---------------- window and mean ----------------

  bf3_mean u_mean (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .clear_i     (cfg_we),
    .valid_i     (a_valid_q),
    .top_i       (rd_line.upper),
    .mid_i       (rd_line.lower),
    .bot_i       (a_sample_q),
    .ctl_i       (a_ctl_q),
    .valid_o     (out_valid),
    .avg_o       (avg),
    .row_end_o   (out_row_end),
    .frame_end_o (out_frame_end)
  );

  always_comb begin
    m_axis_tdata = '0;
    for (int f = 0; f < bf3_pkg::StreamFields; f++) begin
      if (f < bf3_pkg::Channels) begin
        m_axis_tdata[f*bf3_pkg::SampleW +: bf3_pkg::SampleW] = avg[f];
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_row_end;
  assign m_axis_tuser  = out_frame_end;

  // ---------------- checks ----------------

  `BF3_ASSERT_IMPL(a_in_col_range, 1'b1, WEffW'(in_col_q) < w_eff_q)
  `BF3_ASSERT_IMPL(a_out_row_range, 1'b1, HEffW'(out_row_q) < h_eff_q)
  `BF3_ASSERT_IMPL(a_frame_end_ends_row, m_axis_tvalid && m_axis_tuser, m_axis_tlast)
  `BF3_ASSERT_NEXT(a_frame_restart, accept && ctl_d.emit && ctl_d.frame_end && !cfg_we,
                   (in_col_q == '0) && (in_row_q == '0) && (out_col_q == '0))

endmodule
